>>> rtl/core/g711_law_codec_unit_macros.svh
// ---------------------------------------------------------------------------
// G.711 codec assertion macros
// Clocked implication macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef G711_LAW_CODEC_UNIT_MACROS_SVH
`define G711_LAW_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define G711_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("g711 assertion failed");

// Next-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define G711_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("g711 assertion failed");

`endif

>>> rtl/core/g711_pkg.sv
// ---------------------------------------------------------------------------
// G.711 codec package
// Stage payload types, register indexes and companding constants.
// ---------------------------------------------------------------------------
package g711_pkg;

  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgDataWidth = 8;

  localparam logic [CfgIdxWidth-1:0] CfgLawSelect = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDirection = 8'd1;

  localparam logic [15:0] MuClip     = 16'h7F7B;
  localparam logic [15:0] MagMax     = 16'h7FFF;
  localparam logic [14:0] MuBias     = 15'h0084;
  localparam logic [7:0]  AXor       = 8'hD5;
  localparam logic [8:0]  ARoundSeg0 = 9'h008;
  localparam logic [8:0]  ARoundSegN = 9'h108;

  // Stage 1: sign and clipped magnitude, or the de-obfuscated code byte.
  typedef struct packed {
    logic        dir;
    logic        law;
    logic        neg;
    logic [14:0] proc;
    logic [7:0]  code_v;
  } s1_t;

  // Stage 2: segment, magnitude (encode) and interval base (decode).
  typedef struct packed {
    logic        dir;
    logic        law;
    logic        neg;
    logic [2:0]  seg;
    logic [14:0] proc;
    logic [8:0]  base;
  } s2_t;

  // Stage 3: mantissa (encode) and shifted magnitude (decode).
  typedef struct packed {
    logic        dir;
    logic        law;
    logic        neg;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [14:0] mag;
  } s3_t;

  // Stage 4: finished result.
  typedef struct packed {
    logic [15:0] linear_out;
    logic [7:0]  code_out;
  } res_t;

endpackage

>>> rtl/core/g711_prep.sv
// ---------------------------------------------------------------------------
// G.711 stage 1
// Form sign and clipped magnitude, biased for mu-law, or undo the code inversion.
// ---------------------------------------------------------------------------
module g711_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic          dir_i,
  input  logic          law_i,
  input  logic [15:0]   linear_i,
  input  logic [7:0]    code_i,
  output logic          valid_o,
  input  logic          ready_i,
  output g711_pkg::s1_t data_o
);
  import g711_pkg::*;

  logic        valid_q;
  s1_t         data_d, data_q;
  logic [15:0] mag;

  always_comb begin
    mag = linear_i[15] ? (16'h0000 - linear_i) : linear_i;
    data_d        = '0;
    data_d.dir    = dir_i;
    data_d.law    = law_i;
    data_d.code_v = law_i ? (code_i ^ AXor) : ~code_i;
    if (law_i) begin
      data_d.proc = (mag > MagMax) ? MagMax[14:0] : mag[14:0];
    end else begin
      data_d.proc = (mag >= MuClip) ? MagMax[14:0] : (mag[14:0] + MuBias);
    end
    data_d.neg = dir_i ? data_d.code_v[7] : linear_i[15];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> rtl/core/g711_seg.sv
// ---------------------------------------------------------------------------
// G.711 stage 2
// Search the segment thresholds, or form the decode interval base.
// ---------------------------------------------------------------------------
module g711_seg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  g711_pkg::s1_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output g711_pkg::s2_t data_o
);
  import g711_pkg::*;

  logic       valid_q;
  s2_t        data_d, data_q;
  logic [2:0] seg_enc;
  logic [8:0] mant_x16;

  always_comb begin
    // Thresholds rise monotonically, so the last one exceeded is the count.
    seg_enc = 3'd0;
    for (int k = 0; k < 7; k++) begin
      if ({1'b0, data_i.proc} > (16'h00FF << k)) begin
        seg_enc = 3'(k + 1);
      end
    end
    mant_x16 = {1'b0, data_i.code_v[3:0], 4'b0000};

    data_d      = '0;
    data_d.dir  = data_i.dir;
    data_d.law  = data_i.law;
    data_d.neg  = data_i.neg;
    data_d.proc = data_i.proc;
    data_d.seg  = data_i.dir ? data_i.code_v[6:4] : seg_enc;
    if (!data_i.law) begin
      data_d.base = {2'b00, data_i.code_v[3:0], 3'b000} + MuBias[8:0];
    end else if (data_i.code_v[6:4] == 3'd0) begin
      data_d.base = mant_x16 + ARoundSeg0;
    end else begin
      data_d.base = mant_x16 + ARoundSegN;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> rtl/core/g711_shift.sv
// ---------------------------------------------------------------------------
// G.711 stage 3
// Extract the mantissa, or shift the decode base by the segment.
// ---------------------------------------------------------------------------
module g711_shift (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  g711_pkg::s2_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output g711_pkg::s3_t data_o
);
  import g711_pkg::*;

  logic        valid_q;
  s3_t         data_d, data_q;
  logic [3:0]  enc_sh;
  logic [2:0]  dec_sh;
  logic [15:0] mag_sh;

  always_comb begin
    // A-law segment zero keeps a fixed shift of four.
    enc_sh = (data_i.law && (data_i.seg == 3'd0)) ? 4'd4 : ({1'b0, data_i.seg} + 4'd3);
    if (data_i.law) begin
      dec_sh = (data_i.seg == 3'd0) ? 3'd0 : (data_i.seg - 3'd1);
    end else begin
      dec_sh = data_i.seg;
    end
    mag_sh = {7'd0, data_i.base} << dec_sh;

    data_d      = '0;
    data_d.dir  = data_i.dir;
    data_d.law  = data_i.law;
    data_d.neg  = data_i.neg;
    data_d.seg  = data_i.seg;
    data_d.mant = 4'(data_i.proc >> enc_sh);
    data_d.mag  = mag_sh[14:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> rtl/core/g711_pack.sv
// ---------------------------------------------------------------------------
// G.711 stage 4
// Pack and complement the code, or unbias and sign the linear sample.
// ---------------------------------------------------------------------------
module g711_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  g711_pkg::s3_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output g711_pkg::res_t data_o
);
  import g711_pkg::*;

  logic        valid_q;
  res_t        data_d, data_q;
  logic [7:0]  code_raw;
  logic [14:0] mag_f;
  logic [15:0] lin;

  always_comb begin
    code_raw = {data_i.neg, data_i.seg, data_i.mant};
    mag_f    = data_i.law ? data_i.mag : (data_i.mag - MuBias);
    lin      = data_i.neg ? (16'h0000 - {1'b0, mag_f}) : {1'b0, mag_f};

    data_d = '0;
    if (data_i.dir) begin
      data_d.linear_out = lin;
    end else begin
      data_d.code_out = data_i.law ? (code_raw ^ AXor) : ~code_raw;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> rtl/core/g711_law_codec_unit.sv
// ---------------------------------------------------------------------------
// G.711 mu-law / A-law codec
// Four-stage pipeline converting 16-bit linear PCM to and from G.711 bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Write the law (index 0: 0 mu-law, 1 A-law) and the direction (index 1:
//   0 encode, 1 decode) over the cfg channel while the pipeline is empty.
//   Only bit 0 of the data is kept; writes to other indexes are dropped.
//   cfg_ready_o is always high, so a cfg transfer is never stalled.
//   Stream samples on s_axis: linear_in in tdata[15:0], code_in in
//   tdata[23:16]. Results leave on m_axis: linear_out in tdata[15:0],
//   code_out in tdata[23:16]; the field not used by the direction is zero.
//   After an input transfer each item passes one register per stage:
//   sign/clip, segment search, shift, pack; m_axis_tvalid rises once the
//   item sits in the pack register.
//   Throughput is one item per cycle while the receiver keeps m_axis_tready
//   high; every stage may hold an item, so up to four items are in flight.
//   When the receiver stalls, the output register holds its item and the
//   stall passes back combinationally through each occupied register; s_axis_tready falls
//   only once all four stages are full. Nothing is lost or repeated.
//   Reset empties the pipeline and returns both registers to mu-law encode.
// ---------------------------------------------------------------------------
module g711_law_codec_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [g711_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [g711_pkg::CfgDataWidth-1:0] cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // [15:0] linear_in, [23:16] code_in
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata   // [15:0] linear_out, [23:16] code_out
);
  import g711_pkg::*;

  logic law_q, dir_q;

  logic v1, v2, v3, r2, r3, r4;
  s1_t  d1;
  s2_t  d2;
  s3_t  d3;
  res_t res;

  // Configuration is always accepted; hold the low data bit.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q <= 1'b0;
      dir_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgLawSelect) begin
        law_q <= cfg_data_i[0];
      end else if (cfg_index_i == CfgDirection) begin
        dir_q <= cfg_data_i[0];
      end
    end
  end

  // Stage 1: the law and direction ride along with each item from here.
  g711_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .dir_i    (dir_q),
    .law_i    (law_q),
    .linear_i (s_axis_tdata[15:0]),
    .code_i   (s_axis_tdata[23:16]),
    .valid_o  (v1),
    .ready_i  (r2),
    .data_o   (d1)
  );

  // Stage 2: segment search over the seven thresholds.
  g711_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r2),
    .data_i  (d1),
    .valid_o (v2),
    .ready_i (r3),
    .data_o  (d2)
  );

  // Stage 3: mantissa select or segment shift.
  g711_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r3),
    .data_i  (d2),
    .valid_o (v3),
    .ready_i (r4),
    .data_o  (d3)
  );

  // Stage 4: output register facing m_axis.
  g711_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .ready_o (r4),
    .data_i  (d3),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {res.code_out, res.linear_out};
endmodule

>>> rtl/core/g711_checker.sv
// ---------------------------------------------------------------------------
// G.711 codec port checker
// Watch the top-level ports and flag output that breaks the codec's rules.
// ---------------------------------------------------------------------------
`include "g711_law_codec_unit_macros.svh"

module g711_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [7:0]  cfg_index_i,
  input logic [7:0]  cfg_data_i,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import g711_pkg::*;

  logic dir_q;

  // Shadow the direction register from the cfg transfers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgDirection)) begin
      dir_q <= cfg_data_i[0];
    end
  end

  `G711_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `G711_ASSERT_IMP(a_enc_lin_zero, m_axis_tvalid && !dir_q, m_axis_tdata[15:0] == 16'h0000)
  `G711_ASSERT_IMP(a_dec_code_zero, m_axis_tvalid && dir_q, m_axis_tdata[23:16] == 8'h00)
  `G711_ASSERT_IMP(a_dec_no_full_neg, m_axis_tvalid && dir_q, m_axis_tdata[15:0] != 16'h8000)
endmodule

bind g711_law_codec_unit g711_checker u_g711_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/g711_law_codec_unit_tb.sv
// ---------------------------------------------------------------------------
// G.711 codec unit testbench
// Streams linear samples and code bytes through the codec under all four
// law/direction settings. A short table of corner samples comes first, then
// random traffic in several register phases. The sender works in bursts and
// the receiver stalls on its own pattern. An in-bench model of both
// companding laws predicts the results that the table does not give, and
// the output stream is compared against them field by field, in order.
// ---------------------------------------------------------------------------
module g711_law_codec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import g711_pkg::*;

  localparam logic LawMu  = 1'b0;
  localparam logic LawA   = 1'b1;
  localparam logic DirEnc = 1'b0;
  localparam logic DirDec = 1'b1;

  localparam int PhaseItems = 104;
  localparam int NumPhases  = 8;
  localparam int NumVec     = 24;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [15:0] linear_in, [23:16] code_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [15:0] linear_out, [23:16] code_out

  // Directed rows: register setting, both input fields and, where it is
  // obvious, the expected result. Rows with known = 0 go to the model.
  typedef struct {
    logic        law;
    logic        dir;
    logic [15:0] lin;
    logic [7:0]  code;
    bit          known;
    res_t        want;
  } vec_row_t;

  vec_row_t vec_table [NumVec] = '{
    // mu-law encode straight out of reset: zero, the extremes, clip edge
    '{LawMu, DirEnc, 16'h0000, 8'hA5, 1'b1, '{16'h0000, 8'hFF}},
    '{LawMu, DirEnc, 16'h7FFF, 8'hFF, 1'b1, '{16'h0000, 8'h80}},
    '{LawMu, DirEnc, 16'h8000, 8'h5A, 1'b1, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'h0001, 8'h00, 1'b0, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'hFFFF, 8'hFF, 1'b0, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'h7F7A, 8'h3C, 1'b0, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'h7F7B, 8'hC3, 1'b0, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'h8085, 8'h0F, 1'b0, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'd123,  8'hF0, 1'b0, '{16'h0000, 8'h00}},
    '{LawMu, DirEnc, 16'd124,  8'h81, 1'b0, '{16'h0000, 8'h00}},
    // A-law encode: extremes, segment zero and its upper edge
    '{LawA,  DirEnc, 16'h0000, 8'hFF, 1'b1, '{16'h0000, 8'hD5}},
    '{LawA,  DirEnc, 16'h7FFF, 8'h11, 1'b1, '{16'h0000, 8'hAA}},
    '{LawA,  DirEnc, 16'h8000, 8'hEE, 1'b1, '{16'h0000, 8'h2A}},
    '{LawA,  DirEnc, 16'h00F0, 8'h00, 1'b0, '{16'h0000, 8'h00}},
    '{LawA,  DirEnc, 16'h00FF, 8'h7E, 1'b0, '{16'h0000, 8'h00}},
    '{LawA,  DirEnc, 16'h0100, 8'h99, 1'b0, '{16'h0000, 8'h00}},
    '{LawA,  DirEnc, 16'hFFFF, 8'h42, 1'b0, '{16'h0000, 8'h00}},
    // A-law decode: smallest and both largest codes
    '{LawA,  DirDec, 16'h5A5A, 8'hD5, 1'b1, '{16'h0008, 8'h00}},
    '{LawA,  DirDec, 16'hFFFF, 8'hAA, 1'b1, '{16'h7E00, 8'h00}},
    '{LawA,  DirDec, 16'h0000, 8'h2A, 1'b1, '{16'h8200, 8'h00}},
    '{LawA,  DirDec, 16'hA5A5, 8'h55, 1'b0, '{16'h0000, 8'h00}},
    // mu-law decode: zero and both largest codes
    '{LawMu, DirDec, 16'h8000, 8'hFF, 1'b1, '{16'h0000, 8'h00}},
    '{LawMu, DirDec, 16'h7FFF, 8'h80, 1'b1, '{16'h7D7C, 8'h00}},
    '{LawMu, DirDec, 16'h1234, 8'h00, 1'b1, '{16'h8284, 8'h00}}
  };

  // Model copy of the two registers, and the results still owed by the DUT.
  logic law_q = LawMu;
  logic dir_q = DirEnc;
  res_t pending_q[$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  bit  valid_held    = 1'b0;
  int  stall_mode    = 0;
  int  stall_cnt     = 0;

  always #1 clk_i = ~clk_i;

  g711_law_codec_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // -------------------------------------------------------------------------
  // Companding model
  // -------------------------------------------------------------------------

  // Count the thresholds 0xFF << k (k = 0..6) that the magnitude exceeds;
  // the thresholds rise, so this equals the first segment that holds it.
  function automatic logic [2:0] segment_of(logic [15:0] mag);
    logic [2:0] seg;
    seg = 3'd0;
    for (int k = 0; k < 7; k++)
      if (mag > (16'h00FF << k)) seg = 3'(k + 1);
    return seg;
  endfunction

  // Two's complement result from sign and magnitude, saturated to 16 bits.
  function automatic logic [15:0] signed_sample(logic neg, int mag);
    if (neg) return 16'(-((mag > 32768) ? 32768 : mag));
    return 16'((mag > 32767) ? 32767 : mag);
  endfunction

  function automatic logic [7:0] mu_encode(logic [15:0] lin);
    logic        neg;
    logic [15:0] mag;
    logic [15:0] proc;
    logic [2:0]  seg;
    logic [3:0]  mant;
    neg  = lin[15];
    // exact negation: -32768 gives 0x8000 and is clipped below
    mag  = neg ? 16'(-lin) : lin;
    // clipped samples skip the bias
    proc = (mag >= MuClip) ? MagMax : mag + 16'(MuBias);
    seg  = segment_of(proc);
    mant = 4'(proc >> (int'(seg) + 3));
    return ~{neg, seg, mant};
  endfunction

  function automatic logic [7:0] a_encode(logic [15:0] lin);
    logic        neg;
    logic [15:0] mag;
    logic [15:0] proc;
    logic [2:0]  seg;
    logic [3:0]  mant;
    neg  = lin[15];
    mag  = neg ? 16'(-lin) : lin;
    proc = (mag > MagMax) ? MagMax : mag;
    seg  = segment_of(proc);
    // segment zero uses a fixed shift of four
    mant = (seg == 3'd0) ? proc[7:4] : 4'(proc >> (int'(seg) + 3));
    return {neg, seg, mant} ^ AXor;
  endfunction

  function automatic logic [15:0] mu_decode(logic [7:0] code);
    logic [7:0] v;
    int         mag;
    v   = ~code;
    mag = (((int'(v[3:0]) << 3) + int'(MuBias)) << v[6:4]) - int'(MuBias);
    return signed_sample(v[7], mag);
  endfunction

  function automatic logic [15:0] a_decode(logic [7:0] code);
    logic [7:0] v;
    int         mag;
    v   = code ^ AXor;
    mag = int'(v[3:0]) << 4;
    if (v[6:4] == 3'd0) begin
      mag = mag + int'(ARoundSeg0);
    end else begin
      mag = (mag + int'(ARoundSegN)) << (int'(v[6:4]) - 1);
    end
    return signed_sample(v[7], mag);
  endfunction

  // Result under the current register copy; the unused field stays zero.
  function automatic res_t codec_result(logic [15:0] lin, logic [7:0] code);
    res_t r;
    r = '0;
    if (dir_q == DirEnc) begin
      r.code_out = (law_q == LawA) ? a_encode(lin) : mu_encode(lin);
    end else begin
      r.linear_out = (law_q == LawA) ? a_decode(code) : mu_decode(code);
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Configuration writes
  // -------------------------------------------------------------------------

  // Hold one register transfer until it is taken. Valid stays high so that
  // writes can follow back to back; the caller drops it afterwards.
  task automatic cfg_write(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    // only bit 0 counts; other indexes are dropped by the block
    if (idx == CfgLawSelect) law_q = data[0];
    else if (idx == CfgDirection) dir_q = data[0];
  endtask

  // Write both registers with junk in the upper data bits, and now and then
  // a stray index, which must leave the setting alone.
  task automatic write_setting(input logic law, input logic dir);
    cfg_write(CfgLawSelect, {7'($urandom), law});
    cfg_write(CfgDirection, {7'($urandom), dir});
    if ($urandom_range(0, 1) == 1)
      cfg_write(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(2, 254)),
                8'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // -------------------------------------------------------------------------
  // Sample stream
  // -------------------------------------------------------------------------

  // Present one sample, wait for its transfer, then either keep valid high
  // for the next one in the burst or drop it for a random gap.
  task automatic send_item(input logic [15:0] lin, input logic [7:0] code,
                           input bit known, input res_t want);
    s_axis_tdata  <= {code, lin};
    s_axis_tvalid <= 1'b1;
    valid_held = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(known ? want : codec_result(lin, code));
    items_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // mostly short bursts, sometimes a long run with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every owed result has left the block.
  task automatic drain_pipe();
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Random linear sample: fully random, near the mu-law clip, small, or
  // spread within one segment; either sign.
  function automatic logic [15:0] random_linear();
    logic [15:0] lin;
    int          seg;
    case ($urandom_range(0, 3))
      0: lin = 16'($urandom);
      1: lin = 16'(int'(MuClip) + int'($urandom_range(0, 8)) - 4);
      2: lin = 16'($urandom_range(0, 300));
      default: begin
        seg = $urandom_range(0, 7);
        lin = 16'($urandom_range(0, (256 << seg) - 1));
      end
    endcase
    if ($urandom_range(0, 1) == 1) lin = -lin;
    return lin;
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: ready follows a randomly redrawn mode - always
  // ready, coin toss, three in eight, or one in sixteen (long stalls).
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom);
      2: m_axis_tready <= (stall_cnt % 8) < 3;
      default: m_axis_tready <= (stall_cnt % 16) == 0;
    endcase
  end

  // Compare every output transfer with the oldest owed result.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.linear_out = m_axis_tdata[15:0];
      got.code_out   = m_axis_tdata[23:16];
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (got.linear_out !== want.linear_out) begin
          $display("%0t: linear_out mismatch, expected %h got %h",
                   $time, want.linear_out, got.linear_out);
          mismatches++;
        end
        if (got.code_out !== want.code_out) begin
          $display("%0t: code_out mismatch, expected %h got %h",
                   $time, want.code_out, got.code_out);
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [15:0] lin;
    logic [7:0]  code;
    logic        law;
    logic        dir;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(0, 12);

    // Corner rows; the first group runs on the reset setting.
    foreach (vec_table[r]) begin
      if (vec_table[r].law != law_q || vec_table[r].dir != dir_q) begin
        drain_pipe();
        write_setting(vec_table[r].law, vec_table[r].dir);
      end
      send_item(vec_table[r].lin, vec_table[r].code, vec_table[r].known,
                vec_table[r].want);
    end

    // Random phases: the first four walk every law/direction pair, the rest
    // pick at random.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 4) begin
        law = 1'(p);
        dir = 1'(p >> 1);
      end else begin
        law = 1'($urandom);
        dir = 1'($urandom);
      end
      drain_pipe();
      write_setting(law, dir);
      for (int i = 0; i < PhaseItems; i++) begin
        // hold off once mid-phase until the pipeline has emptied
        if (p == 2 && i == PhaseItems / 2) drain_pipe();
        lin  = random_linear();
        code = 8'($urandom);
        send_item(lin, code, 1'b0, '0);
      end
    end

    drain_pipe();
    // let any stray result surface before judging
    repeat (16) @(posedge clk_i);

    $display("Sent %0d samples and checked %0d results over %0d register settings,",
             items_sent, results_seen, settings_used);
    $display("covering mu-law and A-law in both directions with stalls on both sides.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: the slowest legal run needs well under a tenth of this.
  initial begin
    #400us;
    $display("Timeout with %0d results still owed", pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
